FILE: rtl/core/snfcs_pkg.sv
// Shared types, constants and result helpers for the SPI NOR command sequencer.
package snfcs_pkg;

    // Geometry; PAGE_BYTES must be a power of two in 16..4096
    localparam int PAGE_BYTES   = 256;
    localparam int ADDRESS_BITS = 24;
    localparam int PAGE_BITS    = $clog2(PAGE_BYTES);
    localparam int ROOM_W       = PAGE_BITS + 1;

    localparam int MAX_RESULTS  = 7;
    localparam int LEN_W        = $clog2(MAX_RESULTS + 1);
    localparam int NUM_REGS     = 7;
    localparam int REG_IDX_W    = 3;

    // Request codes
    localparam logic [2:0] OP_WRITE_START = 3'd0;
    localparam logic [2:0] OP_WRITE_DATA  = 3'd1;
    localparam logic [2:0] OP_RECEIVED    = 3'd2;
    localparam logic [2:0] OP_READ_START  = 3'd3;
    localparam logic [2:0] OP_SECTOR_ERASE = 3'd4;
    localparam logic [2:0] OP_CHIP_ERASE  = 3'd5;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_WREN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PP   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_READ = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CE   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RDSR = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FILL = 3'd6;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WDATA,
        PH_POLL_OPEN,
        PH_POLL,
        PH_READ
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_WRITE,
        KIND_READ,
        KIND_ERASE
    } t_kind;

    typedef enum logic [2:0] {
        ACT_SEND,
        ACT_RELEASE,
        ACT_DATA,
        ACT_DONE,
        ACT_ERROR
    } t_action;

    typedef struct packed {
        logic [7:0] wren;
        logic [7:0] pp;
        logic [7:0] rd;
        logic [7:0] se;
        logic [7:0] ce;
        logic [7:0] rdsr;
        logic [7:0] fill;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        wren: 8'd6, pp: 8'd2, rd: 8'd3, se: 8'd32, ce: 8'd199, rdsr: 8'd5, fill: 8'd255
    };

    typedef struct packed {
        logic [2:0]  operation;
        logic [23:0] flash_address;
        logic [15:0] byte_count;
        logic [7:0]  data_byte;
    } t_item;

    typedef struct packed {
        t_phase                  phase;
        logic [ADDRESS_BITS-1:0] addr;
        logic [15:0]             left;
        logic [ROOM_W-1:0]       room;
        t_kind                   kind;
    } t_state;

    typedef struct packed {
        t_action    action;
        logic [7:0] data;
    } t_res;

    function automatic t_res res_send(input logic [7:0] b);
        t_res r;
        r.action = ACT_SEND;
        r.data   = b;
        return r;
    endfunction

    function automatic t_res res_ctl(input t_action a);
        t_res r;
        r.action = a;
        r.data   = 8'd0;
        return r;
    endfunction

    function automatic t_res res_data(input logic [7:0] b);
        t_res r;
        r.action = ACT_DATA;
        r.data   = b;
        return r;
    endfunction

    // Bytes left in the page from a given address
    function automatic logic [ROOM_W-1:0] page_room(input logic [ADDRESS_BITS-1:0] a);
        return ROOM_W'(PAGE_BYTES) - ROOM_W'(a[PAGE_BITS-1:0]);
    endfunction

endpackage

FILE: rtl/core/snfcs_decode.sv
// Frame decode: one request plus sequencer state gives the result list and next state.
module snfcs_decode (
    input  snfcs_pkg::t_item                       i_item,
    input  snfcs_pkg::t_state                      i_state,
    input  snfcs_pkg::t_cfg                        i_cfg,
    output snfcs_pkg::t_state                      o_state,
    output snfcs_pkg::t_res [snfcs_pkg::MAX_RESULTS-1:0] o_list,
    output logic [snfcs_pkg::LEN_W-1:0]            o_len
);
    import snfcs_pkg::*;

    logic [ADDRESS_BITS-1:0] in_addr;
    logic [23:0]             in_a24;
    logic [23:0]             cur_a24;
    logic [15:0]             left_dec;
    logic [ROOM_W-1:0]       room_dec;
    logic [ADDRESS_BITS-1:0] addr_inc;
    logic                    idle;

    assign in_addr  = i_item.flash_address[ADDRESS_BITS-1:0];
    assign in_a24   = 24'(in_addr);
    assign cur_a24  = 24'(i_state.addr);
    assign left_dec = i_state.left - 16'd1;
    assign room_dec = i_state.room - ROOM_W'(1);
    assign addr_inc = i_state.addr + ADDRESS_BITS'(1);
    assign idle     = (i_state.phase == PH_IDLE);

    always_comb begin
        o_state = i_state;
        o_list  = '0;
        o_len   = LEN_W'(1);
        o_list[0] = res_ctl(ACT_ERROR);

        case (i_item.operation)
            // Page program: write enable, then opcode and address
            OP_WRITE_START: begin
                if (idle) begin
                    if (i_item.byte_count == 16'd0) begin
                        o_list[0] = res_ctl(ACT_DONE);
                    end else begin
                        o_state.addr  = in_addr;
                        o_state.left  = i_item.byte_count;
                        o_state.kind  = KIND_WRITE;
                        o_state.room  = page_room(in_addr);
                        o_state.phase = PH_WDATA;
                        o_list[0] = res_send(i_cfg.wren);
                        o_list[1] = res_ctl(ACT_RELEASE);
                        o_list[2] = res_send(i_cfg.pp);
                        o_list[3] = res_send(in_a24[23:16]);
                        o_list[4] = res_send(in_a24[15:8]);
                        o_list[5] = res_send(in_a24[7:0]);
                        o_len     = LEN_W'(6);
                    end
                end
            end

            // Data byte; close the frame at page end or request end
            OP_WRITE_DATA: begin
                if (i_state.phase == PH_WDATA) begin
                    o_state.left = left_dec;
                    o_state.room = room_dec;
                    o_state.addr = addr_inc;
                    o_list[0] = res_send(i_item.data_byte);
                    if (room_dec == '0 || left_dec == 16'd0) begin
                        o_list[1]     = res_ctl(ACT_RELEASE);
                        o_len         = LEN_W'(2);
                        o_state.phase = PH_POLL_OPEN;
                    end
                end
            end

            // Received byte: poll opening, status poll or read data
            OP_RECEIVED: begin
                case (i_state.phase)
                    PH_POLL_OPEN: begin
                        o_list[0]     = res_send(i_cfg.rdsr);
                        o_list[1]     = res_send(i_cfg.fill);
                        o_len         = LEN_W'(2);
                        o_state.phase = PH_POLL;
                    end
                    PH_POLL: begin
                        if (i_item.data_byte[0]) begin
                            o_list[0] = res_send(i_cfg.fill);
                        end else if (i_state.kind == KIND_WRITE && i_state.left != 16'd0) begin
                            // next chunk of a split write
                            o_state.room  = page_room(i_state.addr);
                            o_state.phase = PH_WDATA;
                            o_list[0] = res_ctl(ACT_RELEASE);
                            o_list[1] = res_send(i_cfg.wren);
                            o_list[2] = res_ctl(ACT_RELEASE);
                            o_list[3] = res_send(i_cfg.pp);
                            o_list[4] = res_send(cur_a24[23:16]);
                            o_list[5] = res_send(cur_a24[15:8]);
                            o_list[6] = res_send(cur_a24[7:0]);
                            o_len     = LEN_W'(7);
                        end else begin
                            o_state.phase = PH_IDLE;
                            o_state.kind  = KIND_NONE;
                            o_list[0] = res_ctl(ACT_RELEASE);
                            o_list[1] = res_ctl(ACT_DONE);
                            o_len     = LEN_W'(2);
                        end
                    end
                    PH_READ: begin
                        o_state.left = left_dec;
                        o_state.addr = addr_inc;
                        o_list[0] = res_data(i_item.data_byte);
                        if (left_dec != 16'd0) begin
                            o_list[1] = res_send(i_cfg.fill);
                            o_len     = LEN_W'(2);
                        end else begin
                            o_state.phase = PH_IDLE;
                            o_state.kind  = KIND_NONE;
                            o_list[1] = res_ctl(ACT_RELEASE);
                            o_list[2] = res_ctl(ACT_DONE);
                            o_len     = LEN_W'(3);
                        end
                    end
                    default: begin
                        o_list[0] = res_ctl(ACT_ERROR);
                    end
                endcase
            end

            // Read: opcode, address, first filler
            OP_READ_START: begin
                if (idle) begin
                    if (i_item.byte_count == 16'd0) begin
                        o_list[0] = res_ctl(ACT_DONE);
                    end else begin
                        o_state.addr  = in_addr;
                        o_state.left  = i_item.byte_count;
                        o_state.kind  = KIND_READ;
                        o_state.phase = PH_READ;
                        o_list[0] = res_send(i_cfg.rd);
                        o_list[1] = res_send(in_a24[23:16]);
                        o_list[2] = res_send(in_a24[15:8]);
                        o_list[3] = res_send(in_a24[7:0]);
                        o_list[4] = res_send(i_cfg.fill);
                        o_len     = LEN_W'(5);
                    end
                end
            end

            OP_SECTOR_ERASE: begin
                if (idle) begin
                    o_state.addr  = in_addr;
                    o_state.kind  = KIND_ERASE;
                    o_state.phase = PH_POLL_OPEN;
                    o_list[0] = res_send(i_cfg.wren);
                    o_list[1] = res_ctl(ACT_RELEASE);
                    o_list[2] = res_send(i_cfg.se);
                    o_list[3] = res_send(in_a24[23:16]);
                    o_list[4] = res_send(in_a24[15:8]);
                    o_list[5] = res_send(in_a24[7:0]);
                    o_list[6] = res_ctl(ACT_RELEASE);
                    o_len     = LEN_W'(7);
                end
            end

            OP_CHIP_ERASE: begin
                if (idle) begin
                    o_state.kind  = KIND_ERASE;
                    o_state.phase = PH_POLL_OPEN;
                    o_list[0] = res_send(i_cfg.wren);
                    o_list[1] = res_ctl(ACT_RELEASE);
                    o_list[2] = res_send(i_cfg.ce);
                    o_list[3] = res_ctl(ACT_RELEASE);
                    o_len     = LEN_W'(4);
                end
            end

            default: begin
                o_list[0] = res_ctl(ACT_ERROR);
            end
        endcase
    end

endmodule

FILE: rtl/core/spi_nor_flash_command_sequencer_unit.sv
// SPI NOR command sequencer top level: input register, decode, result shift register.
//
//   channel   direction  handshake                 payload
//   in        in         i_in_valid / o_in_stall   i_operation, i_flash_address,
//                                                  i_byte_count, i_data_byte
//   out       out        o_out_valid / i_out_stall o_action, o_out_byte, o_last
//   cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A request waits in the input register, is decoded in one pass and lands in a
// seven-entry result shift register giving one beat per cycle unless the output stalls.
// A request therefore yields 1 to 7 result beats; the single output port draining the
// result register sets the rate.
// The next request is taken into the input register while results are still draining.
// Reset is synchronous; it idles the sequencer and reloads the default opcodes.
// A stall on the output holds the current beat and, once the input register is full,
// raises the input stall.
module spi_nor_flash_command_sequencer_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [2:0]                             i_operation,
    input  logic [23:0]                            i_flash_address,
    input  logic [15:0]                            i_byte_count,
    input  logic [7:0]                             i_data_byte,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [2:0]                             o_action,
    output logic [7:0]                             o_out_byte,
    output logic                                   o_last,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [snfcs_pkg::REG_IDX_W-1:0]        i_cfg_index,
    input  logic [7:0]                             i_cfg_data
);
    import snfcs_pkg::*;

    t_cfg                    r_cfg;
    t_item                   r_item;
    logic                    r_item_valid;
    t_state                  r_state;
    t_res [MAX_RESULTS-1:0]  r_list;
    logic [LEN_W-1:0]        r_left;

    t_state                  n_state;
    t_res [MAX_RESULTS-1:0]  n_list;
    logic [LEN_W-1:0]        n_len;

    logic                    in_accept;
    logic                    pop;
    logic                    load;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_left != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign load        = r_item_valid && (r_left == '0 || (r_left == LEN_W'(1) && pop));
    assign o_in_stall  = r_item_valid && !load;
    assign in_accept   = i_in_valid && !o_in_stall;

    assign o_action    = r_list[0].action;
    assign o_out_byte  = r_list[0].data;
    assign o_last      = (r_left == LEN_W'(1));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_WREN: r_cfg.wren <= i_cfg_data;
                REG_PP:   r_cfg.pp   <= i_cfg_data;
                REG_READ: r_cfg.rd   <= i_cfg_data;
                REG_SE:   r_cfg.se   <= i_cfg_data;
                REG_CE:   r_cfg.ce   <= i_cfg_data;
                REG_RDSR: r_cfg.rdsr <= i_cfg_data;
                REG_FILL: r_cfg.fill <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else begin
            r_item_valid <= in_accept || (r_item_valid && !load);
        end
        if (in_accept) begin
            r_item.operation     <= i_operation;
            r_item.flash_address <= i_flash_address;
            r_item.byte_count    <= i_byte_count;
            r_item.data_byte     <= i_data_byte;
        end
    end

    snfcs_decode u_decode (
        .i_item  (r_item),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_list  (n_list),
        .o_len   (n_len)
    );

    // Sequencer state advances when the decoded beats are loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= PH_IDLE;
            r_state.addr  <= '0;
            r_state.left  <= '0;
            r_state.room  <= '0;
            r_state.kind  <= KIND_NONE;
        end else if (load) begin
            r_state <= n_state;
        end
    end

    // Result shift register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (load) begin
            r_left <= n_len;
        end else if (pop) begin
            r_left <= r_left - LEN_W'(1);
        end
        if (load) begin
            r_list <= n_list;
        end else if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                r_list[i] <= r_list[i+1];
            end
        end
    end

`ifndef SYNTH
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= LEN_W'(MAX_RESULTS))
        else $error("result count out of range");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && o_last && !load) |=> !o_out_valid)
        else $error("beat shown after last result drained");

    a_idle_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_IDLE) |-> (r_state.kind == KIND_NONE))
        else $error("request kind pending while idle");

    a_page_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_WDATA) |-> (r_state.room != '0 && r_state.left != 16'd0))
        else $error("data phase with no room or no bytes");

    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == ACT_ERROR) |-> o_last)
        else $error("error beat not alone");
`endif

endmodule
